@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the reservation block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   `ASSERT_CLK(lbl, clk, rst, !(expr))

`endif

@@ design/msr_pkg.sv @@
// ---------------------------------------------------------------------------
// msr_pkg
// constants and controller/datapath types of the slot reservation block
// ---------------------------------------------------------------------------
package msr_pkg;

   localparam int NUM_RESOURCES = 16;
   localparam int NUM_SLOTS     = 128;

   localparam int TAG_W   = 8;
   localparam int SLOT_W  = 7;
   localparam int COUNT_W = 2;
   localparam int RES_W   = 4;
   localparam int NUM_IDS = 3;
   localparam int IDX_W   = 2;
   localparam int ROW_W   = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

   typedef struct packed {
      logic             ready;
      logic             load;
      logic             rd;
      logic             chk;
      logic             wr;
      logic             finish;
      logic [IDX_W-1:0] idx;
   } msr_cmd_type;

   typedef struct packed {
      logic               req_valid;
      logic               has_range;
      logic               conflict;
      logic               rsp_free;
      logic [COUNT_W-1:0] count;
   } msr_stat_type;

endpackage

@@ design/msr_req_if.sv @@
// ---------------------------------------------------------------------------
// msr_req_if
// request channel: valid/ready handshake with the reservation request
// ---------------------------------------------------------------------------
interface msr_req_if;
   logic                        valid;
   logic                        ready;
   logic [msr_pkg::TAG_W-1:0]   request_tag;
   logic [msr_pkg::SLOT_W-1:0]  start_slot;
   logic [msr_pkg::SLOT_W-1:0]  end_slot;
   logic [msr_pkg::COUNT_W-1:0] resource_count;
   logic [msr_pkg::RES_W-1:0]   resource_first;
   logic [msr_pkg::RES_W-1:0]   resource_second;
   logic [msr_pkg::RES_W-1:0]   resource_third;
   logic                        batch_end;

   modport source (
      output valid, request_tag, start_slot, end_slot, resource_count,
             resource_first, resource_second, resource_third, batch_end,
      input  ready
   );

   modport sink (
      input  valid, request_tag, start_slot, end_slot, resource_count,
             resource_first, resource_second, resource_third, batch_end,
      output ready
   );
endinterface

@@ design/msr_rsp_if.sv @@
// ---------------------------------------------------------------------------
// msr_rsp_if
// verdict channel: valid/ready handshake with the admission verdict
// ---------------------------------------------------------------------------
interface msr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [msr_pkg::TAG_W-1:0] verdict_tag;
   logic                      accepted;
   logic                      verdict_last;

   modport source (
      output valid, verdict_tag, accepted, verdict_last,
      input  ready
   );

   modport sink (
      input  valid, verdict_tag, accepted, verdict_last,
      output ready
   );
endinterface

@@ design/multi_resource_slot_reservation.sv @@
// sequence: from accept, each named row is read and checked; if none conflicts, marked rows are written back,
// then the verdict is loaded into the output register (an empty range or no resources skips the rows)
// throughput: one item in flight; the next is taken once the verdict is in the output register
// the single-port row memory takes one row read or written per cycle
// reset: synchronous, active high; clears the sequencer, the verdict valid bit, the conflict flag and row valid bits
// all rows read as free right after reset, with no clearing pass
// ---------------------------------------------------------------------------
// multi_resource_slot_reservation
// first come first served admission against a per-resource slot bitmap
// ---------------------------------------------------------------------------
module multi_resource_slot_reservation (
   input  logic       clock,
   input  logic       reset,
   msr_req_if.sink    req,
   msr_rsp_if.source  rsp
);

   msr_pkg::msr_cmd_type  cmd;
   msr_pkg::msr_stat_type stat;

   msr_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   msr_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

@@ design/msr_datapath.sv @@
// ---------------------------------------------------------------------------
// msr_datapath
// occupancy row memory, slot mask, conflict check and verdict register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   msr_req_if.sink              req,
   msr_rsp_if.source            rsp,
   input  msr_pkg::msr_cmd_type cmd,
   output msr_pkg::msr_stat_type stat
);

   // occupancy rows, one per resource
   logic [msr_pkg::NUM_SLOTS-1:0]     mem [msr_pkg::NUM_RESOURCES];
   logic [msr_pkg::NUM_RESOURCES-1:0] row_valid_ff;
   logic [msr_pkg::NUM_SLOTS-1:0]     rd_data_ff;

   // captured request
   logic [msr_pkg::TAG_W-1:0]   tag_ff;
   logic [msr_pkg::COUNT_W-1:0] count_ff;
   logic [msr_pkg::RES_W-1:0]   ids_ff [msr_pkg::NUM_IDS];
   logic                        last_ff;
   logic                        has_range_ff;
   logic [msr_pkg::NUM_SLOTS-1:0] mask_ff;
   logic [msr_pkg::NUM_SLOTS-1:0] rows_ff [msr_pkg::NUM_IDS];
   logic                        conflict_ff;

   // verdict register
   logic                      rsp_valid_ff;
   logic [msr_pkg::TAG_W-1:0] rsp_tag_ff;
   logic                      rsp_accepted_ff;
   logic                      rsp_last_ff;

   logic [msr_pkg::NUM_SLOTS-1:0] mask_in;
   logic                          has_range_in;
   int                            hi_clip;
   logic [msr_pkg::ROW_W-1:0]     addr;
   logic                          id_ok;

   // clip end of range to the last existing slot
   always_comb begin
      if (int'(req.end_slot) > msr_pkg::NUM_SLOTS - 1) begin
         hi_clip = msr_pkg::NUM_SLOTS - 1;
      end else begin
         hi_clip = int'(req.end_slot);
      end
      has_range_in = int'(req.start_slot) <= hi_clip;
      for (int s = 0; s < msr_pkg::NUM_SLOTS; s++) begin
         mask_in[s] = (s >= int'(req.start_slot)) && (s <= hi_clip);
      end
   end

   assign addr  = msr_pkg::ROW_W'(ids_ff[cmd.idx]);
   assign id_ok = int'(ids_ff[cmd.idx]) < msr_pkg::NUM_RESOURCES;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tag_ff       <= req.request_tag;
         count_ff     <= req.resource_count;
         ids_ff[0]    <= req.resource_first;
         ids_ff[1]    <= req.resource_second;
         ids_ff[2]    <= req.resource_third;
         last_ff      <= req.batch_end;
         has_range_ff <= has_range_in;
         mask_ff      <= mask_in;
      end
      if (cmd.rd) begin
         rd_data_ff <= row_valid_ff[addr] ? mem[addr] : '0;
      end
      if (cmd.chk) begin
         rows_ff[cmd.idx] <= rd_data_ff;
      end
      if (cmd.wr && id_ok) begin
         mem[addr] <= rows_ff[cmd.idx] | mask_ff;
      end
      if (cmd.finish) begin
         rsp_tag_ff      <= tag_ff;
         rsp_accepted_ff <= !conflict_ff;
         rsp_last_ff     <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         conflict_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // batch end drops every row back to free
         if (cmd.finish && last_ff) begin
            row_valid_ff <= '0;
         end else if (cmd.wr && id_ok) begin
            row_valid_ff[addr] <= 1'b1;
         end

         if (cmd.load) begin
            conflict_ff <= 1'b0;
         end else if (cmd.chk && id_ok && (|(rd_data_ff & mask_ff))) begin
            conflict_ff <= 1'b1;
         end

         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req.ready        = cmd.ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.verdict_tag  = rsp_tag_ff;
   assign rsp.accepted     = rsp_accepted_ff;
   assign rsp.verdict_last = rsp_last_ff;

   assign stat.req_valid = req.valid;
   assign stat.has_range = has_range_ff;
   assign stat.conflict  = conflict_ff;
   assign stat.rsp_free  = !rsp_valid_ff || rsp.ready;
   assign stat.count     = count_ff;

   `ASSERT_NEVER(a_no_rd_wr_overlap, clock, reset, cmd.rd && cmd.wr)
   `ASSERT_CLK(a_finish_needs_room, clock, reset, cmd.finish |-> (!rsp_valid_ff || rsp.ready))
   `ASSERT_CLK(a_batch_clears_rows, clock, reset, (cmd.finish && last_ff) |=> (row_valid_ff == '0))
   `ASSERT_CLK(a_reject_no_write, clock, reset, (cmd.wr) |-> (!conflict_ff && has_range_ff))

endmodule

@@ design/msr_controller.sv @@
// ---------------------------------------------------------------------------
// msr_controller
// sequencer: reads and checks each named row, then writes back marked rows
// ---------------------------------------------------------------------------
module msr_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  msr_pkg::msr_stat_type stat,
   output msr_pkg::msr_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_WRITE,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [msr_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [msr_pkg::IDX_W-1:0] count_idx;

   assign count_idx = msr_pkg::IDX_W'(stat.count);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (stat.conflict || !stat.has_range || idx_ff == count_idx) begin
               idx_in = '0;
               // marking only follows a clean check over a real range
               if (!stat.conflict && stat.has_range && stat.count != '0) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cmd.rd   = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.chk  = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_READ;
         end
         ST_WRITE: begin
            if (idx_ff == count_idx) begin
               state_in = ST_DONE;
            end else begin
               cmd.wr = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
